// ===== hdl/julia_pkg.sv =====
// Shared constants, types and register codes for the Julia escape-time pixel engine.
package julia_pkg;

   // Field and arithmetic widths.
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 26;
   localparam int COUNT_BITS = 16;
   localparam int ZBITS      = FRAC_BITS + 6;
   localparam int ZOOM_W     = 16;
   localparam int ORG_W      = 32;
   localparam int ITER_W     = 16;
   localparam int COLOR_W    = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_REAL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IMAG    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE     = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [ZOOM_W-1:0] ZOOM_RESET     = 16'd256;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd255;

   // Divider for the plane mapping: dividend is the coordinate shifted by the fraction.
   localparam int DIV_W = COORD_BITS + FRAC_BITS;
   localparam int REM_W = ZOOM_W + 1;
   localparam int DCNT_W = $clog2(DIV_W);
   localparam int SUM_W = ((ZBITS > ORG_W) ? ZBITS : ORG_W) + 1;

   // Iteration datapath widths.
   localparam int PROD_W = 2 * ZBITS;
   localparam int ACC_W  = PROD_W + 2;
   localparam int ESC_BIT = 2 * FRAC_BITS + 2;

   // Saturation limits of a z component.
   localparam longint ZMAX = (longint'(1) <<< (ZBITS - 1)) - 1;
   localparam longint ZMIN = -ZMAX - 1;

   // The constant c, rounded to the fixed-point grid, and aligned to the product scale.
   localparam longint C_RE = (285 * (longint'(1) <<< FRAC_BITS) + 500) / 1000;
   localparam longint C_IM = ((longint'(1) <<< FRAC_BITS) + 50) / 100;
   localparam logic signed [ACC_W-1:0] CRE_SH = ACC_W'(C_RE) <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] CIM_SH = ACC_W'(C_IM) <<< FRAC_BITS;

   // Queue between the mapping front end and the iteration engine.
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // A mapped pixel waiting for iteration.
   typedef struct packed {
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic signed [ZBITS-1:0] zr;
      logic signed [ZBITS-1:0] zi;
   } start_type;

   // A finished pixel.
   typedef struct packed {
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic                  write_enable;
      logic [COLOR_W-1:0]    red;
      logic [COLOR_W-1:0]    green;
      logic [COLOR_W-1:0]    blue;
      logic [COUNT_BITS-1:0] iteration_count;
   } result_type;

endpackage

// ===== hdl/julia_escape_time_pixel.sv =====
// Top level of the Julia escape-time pixel engine: configuration registers and wiring.
//
// Usage: pixel coordinates enter through a queue-like port (push, full); a transaction
// happens when push is high and full is low. Results leave through a queue-like port
// (empty, pop); the oldest result is shown while empty is low and is taken when pop is
// high. Configuration is written over the csr_ channel (csr_valid/csr_ready, always
// ready); the user must write it only while no pixel is in flight, and the block
// itself does not enforce that. Timing: the front end maps a pixel with a
// one-bit-per-cycle divider and then hands it off. The iteration engine shares one
// set of three multipliers; each iteration has a multiply state and an add state.
// The front end maps the next pixel while the engine iterates, with a two-entry queue
// between them; it takes a new pixel only after handing the last one to the queue.
// At reset the registers return to zoom 256, origin 0, limit 255, color mode on, and
// all queues empty. When the receiver stalls, the finished result waits in the output
// register, the engine holds its next result, and the front end keeps filling the queue
// until full rises.
module julia_escape_time_pixel (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [julia_pkg::COORD_BITS-1:0]      req_pixel_x,
   input  logic [julia_pkg::COORD_BITS-1:0]      req_pixel_y,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [julia_pkg::COORD_BITS-1:0]      rsp_out_x,
   output logic [julia_pkg::COORD_BITS-1:0]      rsp_out_y,
   output logic                                  rsp_write_enable,
   output logic [julia_pkg::COLOR_W-1:0]         rsp_red,
   output logic [julia_pkg::COLOR_W-1:0]         rsp_green,
   output logic [julia_pkg::COLOR_W-1:0]         rsp_blue,
   output logic [julia_pkg::COUNT_BITS-1:0]      rsp_iteration_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [julia_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [julia_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [julia_pkg::ZOOM_W-1:0]        zoom_ff;
   logic signed [julia_pkg::ORG_W-1:0]  org_re_ff, org_im_ff;
   logic [julia_pkg::ITER_W-1:0]        max_iter_ff;
   logic                                color_ff;
   logic                                fq_push, fq_full, bq_pop, bq_empty;
   julia_pkg::start_type                fq_data, bq_data;
   julia_pkg::result_type               result;

   assign csr_ready = 1'b1;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff     <= julia_pkg::ZOOM_RESET;
         org_re_ff   <= '0;
         org_im_ff   <= '0;
         max_iter_ff <= julia_pkg::MAX_ITER_RESET;
         color_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            julia_pkg::CSR_ZOOM:           zoom_ff     <= csr_wdata[julia_pkg::ZOOM_W-1:0];
            julia_pkg::CSR_ORIGIN_REAL:    org_re_ff   <= csr_wdata[julia_pkg::ORG_W-1:0];
            julia_pkg::CSR_ORIGIN_IMAG:    org_im_ff   <= csr_wdata[julia_pkg::ORG_W-1:0];
            julia_pkg::CSR_MAX_ITERATIONS: max_iter_ff <= csr_wdata[julia_pkg::ITER_W-1:0];
            julia_pkg::CSR_COLOR_MODE:     color_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Plane mapping front end.
   julia_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .zoom        (zoom_ff),
      .origin_real (org_re_ff),
      .origin_imag (org_im_ff),
      .q_push      (fq_push),
      .q_full      (fq_full),
      .q_data      (fq_data)
   );

   // Decoupling queue.
   julia_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .full    (fq_full),
      .wr_data (fq_data),
      .pop     (bq_pop),
      .empty   (bq_empty),
      .rd_data (bq_data)
   );

   // Iteration engine with the result register.
   julia_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (bq_empty),
      .q_data         (bq_data),
      .q_pop          (bq_pop),
      .max_iterations (max_iter_ff),
      .color_mode     (color_ff),
      .pop            (pop),
      .empty          (empty),
      .result         (result)
   );

   assign rsp_out_x           = result.out_x;
   assign rsp_out_y           = result.out_y;
   assign rsp_write_enable    = result.write_enable;
   assign rsp_red             = result.red;
   assign rsp_green           = result.green;
   assign rsp_blue            = result.blue;
   assign rsp_iteration_count = result.iteration_count;

endmodule

// ===== hdl/julia_front.sv =====
// Front end: accepts a pixel and maps it onto the complex plane with a bit-serial divider.
module julia_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [julia_pkg::COORD_BITS-1:0]      pixel_x,
   input  logic [julia_pkg::COORD_BITS-1:0]      pixel_y,
   input  logic [julia_pkg::ZOOM_W-1:0]          zoom,
   input  logic signed [julia_pkg::ORG_W-1:0]    origin_real,
   input  logic signed [julia_pkg::ORG_W-1:0]    origin_imag,
   output logic                                  q_push,
   input  logic                                  q_full,
   output julia_pkg::start_type                  q_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SEND} state_type;

   state_type                               state_ff, state_in;
   logic [julia_pkg::DCNT_W-1:0]            cnt_ff, cnt_in;
   logic [julia_pkg::REM_W-1:0]             div_ff, div_in;
   logic [julia_pkg::REM_W-1:0]             remx_ff, remx_in, remy_ff, remy_in;
   logic [julia_pkg::DIV_W-1:0]             quox_ff, quox_in, quoy_ff, quoy_in;
   logic [julia_pkg::COORD_BITS-1:0]        x_ff, x_in, y_ff, y_in;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   function automatic logic [julia_pkg::REM_W+julia_pkg::DIV_W-1:0] div_step(
      input logic [julia_pkg::REM_W-1:0] rem,
      input logic [julia_pkg::DIV_W-1:0] quo,
      input logic [julia_pkg::REM_W-1:0] dvs);
      logic [julia_pkg::REM_W-1:0] trial;
      logic                        ge;
      trial = {rem[julia_pkg::REM_W-2:0], quo[julia_pkg::DIV_W-1]};
      ge    = (trial >= dvs);
      return {(ge ? trial - dvs : trial), quo[julia_pkg::DIV_W-2:0], ge};
   endfunction

   // Clamp the quotient, add the origin and saturate to the z format.
   function automatic logic signed [julia_pkg::ZBITS-1:0] start_coord(
      input logic [julia_pkg::DIV_W-1:0]       q,
      input logic signed [julia_pkg::ORG_W-1:0] org);
      logic [julia_pkg::ZBITS-2:0]        qc;
      logic signed [julia_pkg::SUM_W-1:0] sum;
      qc  = (|q[julia_pkg::DIV_W-1:julia_pkg::ZBITS-1]) ? '1 : q[julia_pkg::ZBITS-2:0];
      sum = julia_pkg::SUM_W'($signed({1'b0, qc})) + julia_pkg::SUM_W'(org);
      if (sum > julia_pkg::SUM_W'(julia_pkg::ZMAX)) begin
         return julia_pkg::ZBITS'(julia_pkg::ZMAX);
      end else if (sum < julia_pkg::SUM_W'(julia_pkg::ZMIN)) begin
         return julia_pkg::ZBITS'(julia_pkg::ZMIN);
      end
      return julia_pkg::ZBITS'(sum);
   endfunction

   assign full   = (state_ff != ST_IDLE);
   assign q_push = (state_ff == ST_SEND);

   // The mapped point is formed from the finished quotients while it waits for the queue.
   always_comb begin
      q_data.x  = x_ff;
      q_data.y  = y_ff;
      q_data.zr = start_coord(quox_ff, origin_real);
      q_data.zi = start_coord(quoy_ff, origin_imag);
   end

   // Next-state logic: load on accept, divide one bit per cycle, then hand off.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      quox_in  = quox_ff;
      quoy_in  = quoy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               x_in     = pixel_x;
               y_in     = pixel_y;
               // A zero zoom behaves as one.
               div_in   = (zoom == '0) ? julia_pkg::REM_W'(1) : julia_pkg::REM_W'(zoom);
               remx_in  = '0;
               remy_in  = '0;
               quox_in  = {pixel_x, {julia_pkg::FRAC_BITS{1'b0}}};
               quoy_in  = {pixel_y, {julia_pkg::FRAC_BITS{1'b0}}};
               cnt_in   = julia_pkg::DCNT_W'(julia_pkg::DIV_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            {remx_in, quox_in} = div_step(remx_ff, quox_ff, div_ff);
            {remy_in, quoy_in} = div_step(remy_ff, quoy_ff, div_ff);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and datapath registers; only the state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      quox_ff <= quox_in;
      quoy_ff <= quoy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   // The partial remainders always stay below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (remx_ff < div_ff && remy_ff < div_ff))
      else $error("division remainder reached the divisor");

endmodule

// ===== hdl/julia_queue.sv =====
// Two-entry queue of mapped pixels between the front end and the iteration engine.
module julia_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  julia_pkg::start_type wr_data,
   input  logic                 pop,
   output logic                 empty,
   output julia_pkg::start_type rd_data
);

   julia_pkg::start_type              entry_ff [julia_pkg::QDEPTH];
   logic [julia_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [julia_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full    = (cnt_ff == julia_pkg::QCNT_W'(julia_pkg::QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointer and fill-count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == julia_pkg::QPTR_W'(julia_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == julia_pkg::QPTR_W'(julia_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= julia_pkg::QCNT_W'(julia_pkg::QDEPTH))
      else $error("queue fill count exceeded depth");

endmodule

// ===== hdl/julia_back.sv =====
// Iteration engine: runs z = z*z + c on one mapped pixel and holds the finished result.
module julia_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  julia_pkg::start_type               q_data,
   output logic                               q_pop,
   input  logic [julia_pkg::ITER_W-1:0]       max_iterations,
   input  logic                               color_mode,
   input  logic                               pop,
   output logic                               empty,
   output julia_pkg::result_type              result
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD} state_type;

   state_type                              state_ff, state_in;
   logic signed [julia_pkg::ZBITS-1:0]     zr_ff, zr_in, zi_ff, zi_in;
   logic signed [julia_pkg::PROD_W-1:0]    sqr_ff, sqr_in, sqi_ff, sqi_in, crs_ff, crs_in;
   logic [julia_pkg::ITER_W-1:0]           n_ff, n_in;
   logic [julia_pkg::COORD_BITS-1:0]       x_ff, x_in, y_ff, y_in;
   logic                                   out_valid_ff, out_valid_in;
   julia_pkg::result_type                  out_ff, out_in;
   logic signed [julia_pkg::ACC_W-1:0]     acc_re, acc_im, mag;
   logic                                   escaped, stop, load, we;

   // Floor shift back to the z scale and saturate.
   function automatic logic signed [julia_pkg::ZBITS-1:0] sat_z(
      input logic signed [julia_pkg::ACC_W-1:0] v);
      logic signed [julia_pkg::ACC_W-1:0] s;
      s = v >>> julia_pkg::FRAC_BITS;
      if (s > julia_pkg::ACC_W'(julia_pkg::ZMAX)) begin
         return julia_pkg::ZBITS'(julia_pkg::ZMAX);
      end else if (s < julia_pkg::ACC_W'(julia_pkg::ZMIN)) begin
         return julia_pkg::ZBITS'(julia_pkg::ZMIN);
      end
      return julia_pkg::ZBITS'(s);
   endfunction

   assign empty  = !out_valid_ff;
   assign result = out_ff;

   // Sums over the registered products: next z and the squared magnitude of the current z.
   always_comb begin
      acc_re  = julia_pkg::ACC_W'(sqr_ff) - julia_pkg::ACC_W'(sqi_ff) + julia_pkg::CRE_SH;
      acc_im  = (julia_pkg::ACC_W'(crs_ff) <<< 1) + julia_pkg::CIM_SH;
      mag     = julia_pkg::ACC_W'(sqr_ff) + julia_pkg::ACC_W'(sqi_ff);
      escaped = |mag[julia_pkg::ACC_W-1:julia_pkg::ESC_BIT];
      stop    = (n_ff != '0) && (escaped || n_ff >= max_iterations);
      we      = color_mode ? (n_ff != max_iterations) : (n_ff == max_iterations);
   end

   // Result formatting from the final count.
   always_comb begin
      out_in.out_x           = x_ff;
      out_in.out_y           = y_ff;
      out_in.write_enable    = we;
      out_in.iteration_count = julia_pkg::COUNT_BITS'(n_ff);
      if (!we) begin
         out_in.red   = '0;
         out_in.green = '0;
         out_in.blue  = '0;
      end else if (color_mode) begin
         out_in.red   = n_ff[7:0];
         out_in.green = {n_ff[6:0], 1'b0};
         out_in.blue  = n_ff[7:0] + {n_ff[6:0], 1'b0};
      end else begin
         out_in.red   = '1;
         out_in.green = '1;
         out_in.blue  = '1;
      end
   end

   // Sequencer: multiply state, then add state that either finishes once the result register is free, or updates z.
   always_comb begin
      state_in = state_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      sqr_in   = sqr_ff;
      sqi_in   = sqi_ff;
      crs_in   = crs_ff;
      n_in     = n_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               x_in     = q_data.x;
               y_in     = q_data.y;
               zr_in    = q_data.zr;
               zi_in    = q_data.zi;
               n_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sqr_in   = zr_ff * zr_ff;
            sqi_in   = zi_ff * zi_ff;
            crs_in   = zr_ff * zi_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (stop) begin
               // Wait here until the result register is free.
               if (!out_valid_ff || pop) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               zr_in    = sat_z(acc_re);
               zi_in    = sat_z(acc_im);
               n_in     = n_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register handshake.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // State, datapath and result registers; control state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      sqr_ff <= sqr_in;
      sqi_ff <= sqi_in;
      crs_ff <= crs_in;
      n_ff   <= n_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      if (load) begin
         out_ff <= out_in;
      end
   end

   // A finished pixel has run at least one iteration.
   assert property (@(posedge clock) disable iff (reset)
      load |-> (n_ff != '0))
      else $error("result produced with zero iterations");

   // A waiting result is only replaced in the cycle it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (load && out_valid_ff) |-> pop)
      else $error("waiting result overwritten");

   // Each iteration moves the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && !stop) |=> (n_ff == $past(n_ff) + 1'b1))
      else $error("iteration count skipped");

endmodule
